>>> rtl/tcld_pkg.sv
// Package: shared constants and types for the tile cache directory.
`timescale 1ns / 1ps
package tcld_pkg;
  localparam int unsigned EntriesDef = 64;
  localparam int unsigned XW = 32;
  localparam int unsigned ZW = 5;
  localparam int unsigned IdxOutW = 6;
  localparam logic [31:0] StampMax = 32'hFFFFFFFF;

  typedef enum logic {
    OP_LOOKUP  = 1'b0,
    OP_INSTALL = 1'b1
  } op_e;

  // One request as it travels from front to back.
  typedef struct packed {
    op_e             op;
    logic [XW-1:0]   x;
    logic [XW-1:0]   y;
    logic [ZW-1:0]   z;
  } req_t;
endpackage

>>> rtl/tcld_front.sv
// Front end: accepts requests and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module tcld_front import tcld_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  req_t          in_req_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output req_t          q_req_o
);
  req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("queue overflow");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad count");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty");
`endif
endmodule

>>> rtl/tcld_back.sv
// Back end: scans the directory for match and victim, updates entries.
`timescale 1ns / 1ps
module tcld_back import tcld_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  req_t          q_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          hit_o,
  output logic          installed_o,
  output logic          replaced_valid_o,
  output logic [IdxOutW-1:0] entry_index_o
);
  localparam int unsigned IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam logic [CW-1:0] LastIdx = CW'(Entries - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_OUT} state_e;

  // Key and stamp memory, one read port, one write port
  logic [XW-1:0] kx_mem [Entries];
  logic [XW-1:0] ky_mem [Entries];
  logic [ZW-1:0] kz_mem [Entries];
  logic [31:0]   st_mem [Entries];
  logic [Entries-1:0] valid_q;

  state_e state_q;
  req_t   req_q;
  logic [CW-1:0] rd_q;       // address being read
  logic [CW-1:0] cmp_q;      // address of data now on read port
  logic          cmp_v_q;
  logic [XW-1:0] rx_q, ry_q;
  logic [ZW-1:0] rz_q;
  logic [31:0]   rs_q;
  logic          found_q, inv_q;
  logic [IW-1:0] match_q, inv_idx_q, lru_q;
  logic [31:0]   best_q, ctr_q;
  logic          hit_q, inst_q, repl_q;
  logic [IdxOutW-1:0] idx_q;
  logic [IW-1:0] wa_q;
  logic          we_q;
  logic [IW-1:0] ci;
  logic          cv, km;

  assign ci = cmp_q[IW-1:0];
  assign cv = valid_q[ci];
  assign km = cv && rx_q == req_q.x && ry_q == req_q.y && rz_q == req_q.z;

  assign q_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign hit_o = hit_q;
  assign installed_o = inst_q;
  assign replaced_valid_o = repl_q;
  assign entry_index_o = idx_q;

  // Memory read and stamp/key write
  always_ff @(posedge clk_i) begin
    rx_q <= kx_mem[rd_q[IW-1:0]];
    ry_q <= ky_mem[rd_q[IW-1:0]];
    rz_q <= kz_mem[rd_q[IW-1:0]];
    rs_q <= st_mem[rd_q[IW-1:0]];
    if (we_q) begin
      st_mem[wa_q] <= ctr_q;
      if (inst_q) begin
        kx_mem[wa_q] <= req_q.x;
        ky_mem[wa_q] <= req_q.y;
        kz_mem[wa_q] <= req_q.z;
      end
    end
  end

  // Sequencer: one entry compared per cycle, then a write cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ctr_q <= '0;
      rd_q <= '0;
      cmp_q <= '0;
      cmp_v_q <= 1'b0;
      we_q <= 1'b0;
      found_q <= 1'b0;
      inv_q <= 1'b0;
      hit_q <= 1'b0;
      inst_q <= 1'b0;
      repl_q <= 1'b0;
    end else begin
      we_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q <= q_req_i;
            rd_q <= '0;
            cmp_v_q <= 1'b0;
            found_q <= 1'b0;
            inv_q <= 1'b0;
            best_q <= StampMax;
            lru_q <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_q <= rd_q;
          cmp_v_q <= (rd_q <= LastIdx);
          rd_q <= rd_q + 1'b1;
          if (cmp_v_q) begin
            if (km && !found_q) begin
              found_q <= 1'b1;
              match_q <= ci;
            end
            if (!cv && !inv_q) begin
              inv_q <= 1'b1;
              inv_idx_q <= ci;
            end
            if (cv && rs_q < best_q) begin
              best_q <= rs_q;
              lru_q <= ci;
            end
            if (cmp_q == LastIdx) state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          hit_q <= found_q;
          inst_q <= 1'b0;
          repl_q <= 1'b0;
          idx_q <= '0;
          if (found_q) begin
            ctr_q <= ctr_q + 32'd1;
            wa_q <= match_q;
            we_q <= 1'b1;
            idx_q <= IdxOutW'({{32{1'b0}}, match_q});
          end else if (req_q.op == OP_INSTALL) begin
            ctr_q <= ctr_q + 32'd1;
            inst_q <= 1'b1;
            repl_q <= !inv_q;
            wa_q <= inv_q ? inv_idx_q : lru_q;
            valid_q[inv_q ? inv_idx_q : lru_q] <= 1'b1;
            we_q <= 1'b1;
            idx_q <= IdxOutW'({{32{1'b0}}, (inv_q ? inv_idx_q : lru_q)});
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && installed_o)) else $error("hit and install");
  a_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replaced_valid_o |-> installed_o) else $error("repl w/o install");
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_q |-> state_q == S_OUT) else $error("stray write");
`endif
endmodule

>>> rtl/tile_cache_lru_directory_unit.sv
// Top level: tile cache LRU tag directory.
// The back end takes no new request until its last result has been taken.
// Its tag scan compares one entry per cycle.
// A two-deep request queue lets the front accept while the back scans.
// Reset (async, active low) clears all valid bits and the access counter at once.
`timescale 1ns / 1ps
module tile_cache_lru_directory_unit import tcld_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] tile_x_i,
  input  logic signed [31:0] tile_y_i,
  input  logic [4:0]         zoom_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic               installed_o,
  output logic               replaced_valid_o,
  output logic [5:0]         entry_index_o
);
  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req.op = op_e'(operation_i);
  assign in_req.x = tile_x_i;
  assign in_req.y = tile_y_i;
  assign in_req.z = zoom_level_i;

  tcld_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  tcld_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .hit_o, .installed_o, .replaced_valid_o,
    .entry_index_o
  );
endmodule
